FILE: hdl/vpic_pkg.sv
// package with shared types, constants and the pair match function
package vpic_pkg;

  localparam int PHASE_W = 8;
  localparam int DIM_W   = 9;
  localparam int COUNT_W = 27;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_PHASE_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_X   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_Y   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_Z   = 3'd4;

  localparam logic [PHASE_W-1:0] PHASE_A_RESET = 8'd0;
  localparam logic [PHASE_W-1:0] PHASE_B_RESET = 8'd1;
  localparam logic [DIM_W-1:0]   DIM_RESET     = 9'd256;

  typedef struct packed {
    logic [PHASE_W-1:0] phase_a;
    logic [PHASE_W-1:0] phase_b;
    logic [DIM_W-1:0]   dim_x;
    logic [DIM_W-1:0]   dim_y;
    logic [DIM_W-1:0]   dim_z;
  } cfg_t;

  typedef struct packed {
    logic has_x;
    logic has_y;
    logic has_z;
    logic last;
  } nbr_t;

  function automatic logic [1:0] pair_hits(logic [PHASE_W-1:0] cur, logic [PHASE_W-1:0] nb,
                                           logic [PHASE_W-1:0] pa, logic [PHASE_W-1:0] pb);
    logic [1:0] ab;
    logic [1:0] ba;
    ab = {1'b0, (cur == pa) && (nb == pb)};
    ba = {1'b0, (cur == pb) && (nb == pa)};
    return ab + ba;
  endfunction

endpackage

FILE: hdl/vpic_if.sv
// stream interfaces for voxels, counts and configuration writes
interface vpic_voxel_if;
  logic       valid;
  logic       ready;
  logic [7:0] voxel_phase;
  modport source (output valid, output voxel_phase, input ready);
  modport sink (input valid, input voxel_phase, output ready);
endinterface

interface vpic_count_if;
  logic        valid;
  logic        ready;
  logic [26:0] face_count;
  modport source (output valid, output face_count, input ready);
  modport sink (input valid, input face_count, output ready);
endinterface

interface vpic_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [8:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hdl/voxel_phase_interface_counter.sv
// top level: 6-connected phase interface face counter over a streamed voxel grid
//
//   channel   modport  payload            role
//   voxel_i   sink     voxel_phase [7:0]  one voxel per transaction, z fastest
//   count_o   source   face_count [26:0]  one total per completed grid
//   cfg_i     sink     index [2:0], data  register write, always ready
//
// one voxel per cycle unless a last voxel is held: address and plane store read
// in the issue stage, match, count update and store write-back in the match stage
// same-entry read after write is forwarded from the write-back stage
// the plane store needs no clearing pass; reset clears counters and registers only
// a grid's last voxel waits until the output register is free, so a stalled
// result holds only that voxel back; all others keep flowing
module voxel_phase_interface_counter
  import vpic_pkg::*;
#(
  parameter int MAX_X = 256,
  parameter int MAX_Y = 256,
  parameter int MAX_Z = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  vpic_voxel_if.sink   voxel_i,
  vpic_count_if.source count_o,
  vpic_cfg_if.sink     cfg_i
);

  localparam int DEPTH = MAX_Y * MAX_Z;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cfg_t cfg;
  nbr_t scan_flags;
  logic [AW-1:0] addr_self, addr_up;
  logic accept;

  logic               s1_valid_q;
  logic [PHASE_W-1:0] s1_voxel_q;
  nbr_t               s1_flags_q;
  logic [AW-1:0]      s1_waddr_q;
  logic               fwd_self_q, fwd_up_q;
  logic [PHASE_W-1:0] fwd_data_q;
  logic [PHASE_W-1:0] prev_voxel_q;
  logic [COUNT_W-1:0] count_q, count_d;
  logic               out_valid_q, out_valid_d;
  logic [COUNT_W-1:0] out_count_q, out_count_d;

  logic [PHASE_W-1:0] rd_self, rd_up, nb_x, nb_y;
  logic [1:0]         hit_x, hit_y, hit_z;
  logic [2:0]         add;
  logic [COUNT_W:0]   sum;
  logic [COUNT_W-1:0] sat;
  logic               s1_last;

  vpic_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  vpic_scan #(
    .MAX_X (MAX_X),
    .MAX_Y (MAX_Y),
    .MAX_Z (MAX_Z)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .advance_i   (accept),
    .addr_self_o (addr_self),
    .addr_up_o   (addr_up),
    .flags_o     (scan_flags)
  );

  vpic_ram #(
    .WIDTH (PHASE_W),
    .DEPTH (DEPTH)
  ) u_plane (
    .clk_i     (clk_i),
    .we_i      (s1_valid_q),
    .waddr_i   (s1_waddr_q),
    .wdata_i   (s1_voxel_q),
    .re_i      (accept),
    .raddr_a_i (addr_self),
    .raddr_b_i (addr_up),
    .rdata_a_o (rd_self),
    .rdata_b_o (rd_up)
  );

  assign s1_last = s1_valid_q && s1_flags_q.last;
  assign voxel_i.ready = !scan_flags.last || (!out_valid_q && !s1_last);
  assign accept = voxel_i.valid && voxel_i.ready;

  // stage one issue and forwarding capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_voxel_q <= voxel_i.voxel_phase;
      s1_flags_q <= scan_flags;
      s1_waddr_q <= addr_self;
      fwd_self_q <= s1_valid_q && (addr_self == s1_waddr_q);
      fwd_up_q   <= s1_valid_q && (addr_up == s1_waddr_q);
      fwd_data_q <= s1_voxel_q;
    end
  end

  // stage two match and accumulate
  always_comb begin
    nb_x  = fwd_self_q ? fwd_data_q : rd_self;
    nb_y  = fwd_up_q ? fwd_data_q : rd_up;
    hit_x = s1_flags_q.has_x ? pair_hits(s1_voxel_q, nb_x, cfg.phase_a, cfg.phase_b) : 2'd0;
    hit_y = s1_flags_q.has_y ? pair_hits(s1_voxel_q, nb_y, cfg.phase_a, cfg.phase_b) : 2'd0;
    hit_z = s1_flags_q.has_z ?
            pair_hits(s1_voxel_q, prev_voxel_q, cfg.phase_a, cfg.phase_b) : 2'd0;
    add   = 3'(hit_x) + 3'(hit_y) + 3'(hit_z);
    sum   = {1'b0, count_q} + (COUNT_W + 1)'(add);
    sat   = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];

    count_d     = count_q;
    out_valid_d = out_valid_q;
    out_count_d = out_count_q;
    if (out_valid_q && count_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (s1_valid_q) begin
      if (s1_flags_q.last) begin
        count_d     = '0;
        out_valid_d = 1'b1;
        out_count_d = sat;
      end else begin
        count_d = sat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      prev_voxel_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (s1_valid_q) begin
        prev_voxel_q <= s1_voxel_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_count_q <= out_count_d;
  end

  assign count_o.valid      = out_valid_q;
  assign count_o.face_count = out_count_q;

  a_result_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_last |-> !out_valid_q)
    else $error("grid total reached a full output register");

  a_issue_to_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("accepted voxel missing from match stage");

  a_last_tracked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && scan_flags.last) |=> s1_last)
    else $error("last voxel flag lost between stages");

  a_total_emitted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_last |=> (out_valid_q && (count_q == '0)))
    else $error("grid end did not emit total and clear count");

endmodule

FILE: hdl/vpic_ram.sv
// generic ram, one write port and two registered read ports
module vpic_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]                        rdata_a_o,
  output logic [WIDTH-1:0]                        rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

FILE: hdl/vpic_cfg_regs.sv
// configuration register file
module vpic_cfg_regs
  import vpic_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  vpic_cfg_if.sink cfg_i,
  output cfg_t cfg_o
);

  cfg_t cfg_q;
  cfg_t cfg_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_PHASE_A: cfg_d.phase_a = cfg_i.data[PHASE_W-1:0];
        REG_PHASE_B: cfg_d.phase_b = cfg_i.data[PHASE_W-1:0];
        REG_DIM_X:   cfg_d.dim_x = cfg_i.data;
        REG_DIM_Y:   cfg_d.dim_y = cfg_i.data;
        REG_DIM_Z:   cfg_d.dim_z = cfg_i.data;
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.phase_a <= PHASE_A_RESET;
      cfg_q.phase_b <= PHASE_B_RESET;
      cfg_q.dim_x   <= DIM_RESET;
      cfg_q.dim_y   <= DIM_RESET;
      cfg_q.dim_z   <= DIM_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: hdl/vpic_scan.sv
// raster position counters and plane store address generation
module vpic_scan
  import vpic_pkg::*;
#(
  parameter int MAX_X = 256,
  parameter int MAX_Y = 256,
  parameter int MAX_Z = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic advance_i,
  output logic [((MAX_Y * MAX_Z > 1) ? $clog2(MAX_Y * MAX_Z) : 1)-1:0] addr_self_o,
  output logic [((MAX_Y * MAX_Z > 1) ? $clog2(MAX_Y * MAX_Z) : 1)-1:0] addr_up_o,
  output nbr_t flags_o
);

  localparam int XW  = (MAX_X > 1) ? $clog2(MAX_X) : 1;
  localparam int YW  = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
  localparam int ZW  = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
  localparam int XDW = $clog2(MAX_X + 1);
  localparam int YDW = $clog2(MAX_Y + 1);
  localparam int ZDW = $clog2(MAX_Z + 1);
  localparam int AW  = (MAX_Y * MAX_Z > 1) ? $clog2(MAX_Y * MAX_Z) : 1;
  localparam int PW  = YW + ZDW;

  logic [XW-1:0] pos_x_q, pos_x_d;
  logic [YW-1:0] pos_y_q, pos_y_d;
  logic [ZW-1:0] pos_z_q, pos_z_d;
  logic [XDW-1:0] nx;
  logic [YDW-1:0] ny;
  logic [ZDW-1:0] nz;
  logic last_x, last_y, last_z;
  logic [PW-1:0] idx;

  // zero acts as one, oversized clamps to the maximum
  always_comb begin
    if (cfg_i.dim_x == '0) begin
      nx = XDW'(1);
    end else if (32'(cfg_i.dim_x) > MAX_X) begin
      nx = XDW'(MAX_X);
    end else begin
      nx = XDW'(cfg_i.dim_x);
    end
    if (cfg_i.dim_y == '0) begin
      ny = YDW'(1);
    end else if (32'(cfg_i.dim_y) > MAX_Y) begin
      ny = YDW'(MAX_Y);
    end else begin
      ny = YDW'(cfg_i.dim_y);
    end
    if (cfg_i.dim_z == '0) begin
      nz = ZDW'(1);
    end else if (32'(cfg_i.dim_z) > MAX_Z) begin
      nz = ZDW'(MAX_Z);
    end else begin
      nz = ZDW'(cfg_i.dim_z);
    end
  end

  assign last_x = (32'(pos_x_q) + 32'd1) >= 32'(nx);
  assign last_y = (32'(pos_y_q) + 32'd1) >= 32'(ny);
  assign last_z = (32'(pos_z_q) + 32'd1) >= 32'(nz);

  assign idx = PW'(pos_y_q) * PW'(nz) + PW'(pos_z_q);
  assign addr_self_o = AW'(idx);
  assign addr_up_o   = AW'(idx - PW'(nz));

  assign flags_o.has_x = pos_x_q != '0;
  assign flags_o.has_y = pos_y_q != '0;
  assign flags_o.has_z = pos_z_q != '0;
  assign flags_o.last  = last_x && last_y && last_z;

  always_comb begin
    pos_x_d = pos_x_q;
    pos_y_d = pos_y_q;
    pos_z_d = pos_z_q;
    if (advance_i) begin
      if (!last_z) begin
        pos_z_d = pos_z_q + ZW'(1);
      end else begin
        pos_z_d = '0;
        if (!last_y) begin
          pos_y_d = pos_y_q + YW'(1);
        end else begin
          pos_y_d = '0;
          if (!last_x) begin
            pos_x_d = pos_x_q + XW'(1);
          end else begin
            pos_x_d = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= '0;
      pos_y_q <= '0;
      pos_z_q <= '0;
    end else begin
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
      pos_z_q <= pos_z_d;
    end
  end

endmodule

FILE: tb/voxel_phase_interface_counter_tb.sv
// testbench for the 6-connected phase interface face counter
`timescale 1ns / 1ps

module voxel_phase_interface_counter_tb;
  import vpic_pkg::*;

  localparam int unsigned MAX_AXIS       = 256;
  localparam int unsigned COUNT_MAX      = (1 << COUNT_W) - 1;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned RX_HOLD_CYCLES = 400;
  localparam int unsigned RANDOM_VOXELS  = 380;
  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = REG_DIM_Z + 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = {CFG_IDX_W{1'b1}};

  logic clk_i;
  logic rst_ni;

  vpic_voxel_if voxel_if ();
  vpic_count_if count_if ();
  vpic_cfg_if   cfg_if ();

  voxel_phase_interface_counter #(
    .MAX_X(MAX_AXIS),
    .MAX_Y(MAX_AXIS),
    .MAX_Z(MAX_AXIS)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .voxel_i(voxel_if),
    .count_o(count_if),
    .cfg_i  (cfg_if)
  );

  // predictor state
  cfg_t cfg_model = '{PHASE_A_RESET, PHASE_B_RESET, DIM_RESET, DIM_RESET, DIM_RESET};
  logic [PHASE_W-1:0] plane_copy [0:MAX_AXIS*MAX_AXIS-1];
  logic [PHASE_W-1:0] last_voxel = '0;
  int unsigned pos_x = 0;
  int unsigned pos_y = 0;
  int unsigned pos_z = 0;
  int unsigned faces_so_far = 0;
  logic [COUNT_W-1:0] face_totals_due [$];

  int unsigned voxels_sent    = 0;
  int unsigned grids_sent     = 0;
  int unsigned totals_checked = 0;
  int unsigned error_count    = 0;
  int unsigned cycle_count    = 0;
  int unsigned src_idle_pct   = 29;
  int unsigned snk_idle_pct   = 72;
  int unsigned rx_hold_requests = 0;
  int unsigned rx_holds_seen    = 0;
  int unsigned rx_hold_left     = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_size(logic [DIM_W-1:0] d);
    if (d == '0) return 1;
    return (d > MAX_AXIS) ? MAX_AXIS : int'(d);
  endfunction

  function automatic int unsigned phase_pair_matches(logic [PHASE_W-1:0] cur,
                                                     logic [PHASE_W-1:0] nb);
    int unsigned n;
    n = 0;
    if (cur == cfg_model.phase_a && nb == cfg_model.phase_b) n++;
    if (cur == cfg_model.phase_b && nb == cfg_model.phase_a) n++;
    return n;
  endfunction

  function automatic void predict_face_total(logic [PHASE_W-1:0] v);
    int unsigned nx;
    int unsigned ny;
    int unsigned nz;
    int unsigned idx;
    int unsigned add;
    nx  = eff_size(cfg_model.dim_x);
    ny  = eff_size(cfg_model.dim_y);
    nz  = eff_size(cfg_model.dim_z);
    idx = pos_y * nz + pos_z;
    add = 0;
    if (pos_x > 0) add += phase_pair_matches(v, plane_copy[idx]);
    if (pos_y > 0) add += phase_pair_matches(v, plane_copy[idx - nz]);
    if (pos_z > 0) add += phase_pair_matches(v, last_voxel);
    faces_so_far += add;
    if (faces_so_far > COUNT_MAX) faces_so_far = COUNT_MAX;
    plane_copy[idx] = v;
    last_voxel = v;
    if (pos_z + 1 < nz) begin
      pos_z++;
      return;
    end
    pos_z = 0;
    if (pos_y + 1 < ny) begin
      pos_y++;
      return;
    end
    pos_y = 0;
    if (pos_x + 1 < nx) begin
      pos_x++;
      return;
    end
    pos_x = 0;
    face_totals_due = {face_totals_due, faces_so_far[COUNT_W-1:0]};
    faces_so_far = 0;
  endfunction

  // mostly the two watched phases so that faces actually match
  function automatic logic [PHASE_W-1:0] pick_voxel();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 4) return cfg_model.phase_a;
    if (r < 7) return cfg_model.phase_b;
    return PHASE_W'($urandom_range(255));
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    int unsigned r;
    r = $urandom_range(19);
    if (r == 0) return '0;
    if (r <= 15) return DIM_W'($urandom_range(3, 1));
    return DIM_W'($urandom_range(6, 4));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_phase_data(logic [PHASE_W-1:0] p);
    return {1'($urandom_range(1)), p};
  endfunction

  task automatic send_voxel(input logic [PHASE_W-1:0] v);
    while ($urandom_range(99) < src_idle_pct) begin
      voxel_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    voxel_if.valid       <= 1'b1;
    voxel_if.voxel_phase <= v;
    @(posedge clk_i);
    while (!voxel_if.ready) @(posedge clk_i);
    predict_face_total(v);
    voxels_sent++;
  endtask

  task automatic send_grid();
    int unsigned n;
    n = eff_size(cfg_model.dim_x) * eff_size(cfg_model.dim_y) * eff_size(cfg_model.dim_z);
    repeat (n) send_voxel(pick_voxel());
    grids_sent++;
  endtask

  task automatic wait_idle();
    voxel_if.valid <= 1'b0;
    while (face_totals_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    case (idx)
      REG_PHASE_A: cfg_model.phase_a = data[PHASE_W-1:0];
      REG_PHASE_B: cfg_model.phase_b = data[PHASE_W-1:0];
      REG_DIM_X:   cfg_model.dim_x = data;
      REG_DIM_Y:   cfg_model.dim_y = data;
      REG_DIM_Z:   cfg_model.dim_z = data;
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [CFG_DATA_W-1:0] pa, input logic [CFG_DATA_W-1:0] pb,
                               input logic [CFG_DATA_W-1:0] dx, input logic [CFG_DATA_W-1:0] dy,
                               input logic [CFG_DATA_W-1:0] dz);
    wait_idle();
    write_reg(REG_PHASE_A, pa);
    write_reg(REG_PHASE_B, pb);
    write_reg(REG_DIM_X, dx);
    write_reg(REG_DIM_Y, dy);
    write_reg(REG_DIM_Z, dz);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic random_setting();
    logic [PHASE_W-1:0] pa;
    logic [PHASE_W-1:0] pb;
    pa = PHASE_W'($urandom_range(255));
    pb = ($urandom_range(5) == 0) ? pa : PHASE_W'($urandom_range(255));
    apply_setting(pick_phase_data(pa), pick_phase_data(pb), pick_dim(), pick_dim(), pick_dim());
  endtask

  // phases keep their reset values, only the sizes are written
  task automatic test_reset_phases();
    write_reg(REG_DIM_X, 9'd2);
    write_reg(REG_DIM_Y, 9'd2);
    write_reg(REG_DIM_Z, 9'd2);
    cfg_if.valid <= 1'b0;
    for (int i = 0; i < 8; i++) begin
      send_voxel((i[0] ^ i[1]) ? PHASE_B_RESET : PHASE_A_RESET);
    end
    grids_sent++;
  endtask

  task automatic test_directed();
    wait_idle();
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_SPARE_HI, '0);
    cfg_if.valid <= 1'b0;
    // single voxel grid has no faces
    apply_setting(9'h1FF, 9'h000, 9'd1, 9'd1, 9'd1);
    send_voxel(8'hFF);
    grids_sent++;
    // zero sizes act as one, phase data bit 8 is dropped
    apply_setting(9'h0FF, 9'h100, 9'd0, 9'd2, 9'd0);
    send_voxel(8'hFF);
    send_voxel(8'h00);
    grids_sent++;
    apply_setting(9'h1FF, 9'h000, 9'd2, 9'd2, 9'd2);
    for (int i = 0; i < 8; i++) begin
      send_voxel((i[0] ^ i[2]) ? 8'hFF : 8'h00);
    end
    grids_sent++;
    // equal phases count each like face twice
    apply_setting(9'd77, 9'd77, 9'd2, 9'd1, 9'd2);
    repeat (4) send_voxel(8'd77);
    grids_sent++;
  endtask

  task automatic test_size_extremes();
    apply_setting(pick_phase_data(8'd3), pick_phase_data(8'd200), 9'd256, 9'd1, 9'd1);
    send_grid();
    apply_setting(pick_phase_data(8'd0), pick_phase_data(8'd255), 9'd1, 9'd300, 9'd0);
    send_grid();
    apply_setting(pick_phase_data(8'd9), pick_phase_data(8'd9), 9'd1, 9'd1, 9'd511);
    send_grid();
  endtask

  // results back up behind a long receiver hold-off and stall the voxel input
  task automatic test_backpressure();
    apply_setting(pick_phase_data(8'd5), pick_phase_data(8'd6), 9'd2, 9'd2, 9'd2);
    rx_hold_requests++;
    repeat (6) send_grid();
    wait_idle();
    send_grid();
    wait_idle();
    send_grid();
  endtask

  task automatic test_random_grids();
    int unsigned start;
    int unsigned done;
    start = voxels_sent;
    while (voxels_sent - start < RANDOM_VOXELS) begin
      done = voxels_sent - start;
      if (done < RANDOM_VOXELS / 3) begin
        src_idle_pct = 29;
        snk_idle_pct = 72;
      end else if (done < 2 * RANDOM_VOXELS / 3) begin
        src_idle_pct = 72;
        snk_idle_pct = 29;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      random_setting();
      repeat ($urandom_range(4, 1)) send_grid();
    end
  endtask

  initial begin
    count_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_holds_seen != rx_hold_requests) begin
        rx_holds_seen = rx_hold_requests;
        rx_hold_left  = RX_HOLD_CYCLES;
      end
      if (!rst_ni) begin
        count_if.ready <= 1'b0;
      end else if (rx_hold_left != 0) begin
        rx_hold_left--;
        count_if.ready <= 1'b0;
      end else begin
        count_if.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && count_if.valid && count_if.ready) begin
      if (face_totals_due.size() == 0) begin
        $display("%0t: unexpected face_count transaction, expected none, actual %0d",
                 $time, count_if.face_count);
        error_count++;
      end else begin
        if (count_if.face_count !== face_totals_due[0]) begin
          $display("%0t: face_count mismatch, expected %0d, actual %0d",
                   $time, face_totals_due[0], count_if.face_count);
          error_count++;
        end
        void'(face_totals_due.pop_front());
        totals_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d totals outstanding",
               cycle_count, face_totals_due.size());
      $display("voxel_phase_interface_counter regression: fail");
      $finish;
    end
  end

  initial begin
    rst_ni               <= 1'b0;
    voxel_if.valid       <= 1'b0;
    voxel_if.voxel_phase <= '0;
    cfg_if.valid         <= 1'b0;
    cfg_if.index         <= '0;
    cfg_if.data          <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_phases();
    test_directed();
    test_size_extremes();
    test_backpressure();
    test_random_grids();
    wait_idle();

    $display("sent %0d voxels in %0d grids, checked %0d face totals, %0d errors",
             voxels_sent, grids_sent, totals_checked, error_count);
    $display("covered reset phases, zero and oversized sizes, full-length axes, equal phases,");
    $display("a long result hold-off and three idle mixes on both channels");
    if (error_count == 0) begin
      $display("voxel_phase_interface_counter regression: pass");
    end else begin
      $display("voxel_phase_interface_counter regression: fail");
    end
    $finish;
  end

endmodule
